### design/mdsu_pkg.sv
// Shared types and arithmetic helpers of the masked diffusion stencil update core.
// Holds the operation, neighbour, state and control types and the Q8.24 saturation.
// Depends on nothing; every other design file imports it.
package mdsu_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_SWAP   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_TIME_STEP  = 2'd0,
        REG_DIFF_GAIN  = 2'd1,
        REG_CELL_GAIN  = 2'd2,
        REG_DECAY_RATE = 2'd3
    } t_reg;

    // Order in which the stencil words are fetched; the centre comes first.
    typedef enum logic [2:0] {
        NB_C  = 3'd0,
        NB_XM = 3'd1,
        NB_XP = 3'd2,
        NB_YM = 3'd3,
        NB_YP = 3'd4,
        NB_ZM = 3'd5,
        NB_ZP = 3'd6
    } t_nb;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_READ,
        S_RD_LAST,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_SUM,
        S_MUL_R,
        S_WRITE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_DIFF,
        MUL_SRC,
        MUL_DECAY,
        MUL_STEP
    } t_mul_sel;

    typedef struct packed {
        logic rd;
        logic wr_conc;
        logic wr_mask;
        logic buf_sel;
        logic mask_val;
    } t_grid_ctl;

    typedef struct packed {
        logic     cap_c;
        logic     acc_en;
        t_mul_sel mul_sel;
        logic     cap_a;
        logic     cap_b;
        logic     cap_r;
    } t_alu_ctl;

    localparam int DATA_W = 32;
    localparam int COEF_W = 31;
    localparam int FRAC_W = 24;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Reduces a 5-bit coordinate modulo size (at least 4) by repeated subtraction.
    function automatic logic [8:0] wrap_coord(input logic [4:0] v, input int size);
        logic [8:0] r;
        r = {4'b0000, v};
        for (int i = 0; i < 8; i++) begin
            if (r >= 9'(size)) begin
                r = r - 9'(size);
            end
        end
        return r;
    endfunction

endpackage

### design/mdsu_addr.sv
// Stencil address generator: turns a voxel coordinate and a neighbour code into a
// flat voxel index, wrapping in x and y and reflecting in z. Uses mdsu_pkg.
module mdsu_addr import mdsu_pkg::*; #(
    parameter int X_SIZE = 32,
    parameter int Y_SIZE = 32,
    parameter int Z_TOP  = 16,
    parameter int XW     = 5,
    parameter int YW     = 5,
    parameter int ZW     = 5,
    parameter int IW     = 15
) (
    input  logic [XW-1:0] i_x,
    input  logic [YW-1:0] i_y,
    input  logic [ZW-1:0] i_z,
    input  t_nb           i_nb,
    output logic [IW-1:0] o_idx
);

    localparam int ZN = Z_TOP + 1;
    localparam int YZ = Y_SIZE * ZN;

    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic [ZW-1:0] nz;

    always_comb begin
        nx = i_x;
        ny = i_y;
        nz = i_z;
        case (i_nb)
            NB_C: begin
            end
            NB_XM: nx = (i_x == '0) ? XW'(X_SIZE - 1) : i_x - XW'(1);
            NB_XP: nx = (i_x == XW'(X_SIZE - 1)) ? '0 : i_x + XW'(1);
            NB_YM: ny = (i_y == '0) ? YW'(Y_SIZE - 1) : i_y - YW'(1);
            NB_YP: ny = (i_y == YW'(Y_SIZE - 1)) ? '0 : i_y + YW'(1);
            // The planes beyond either end mirror onto their inner neighbour.
            NB_ZM: nz = (i_z == '0) ? ZW'(1) : i_z - ZW'(1);
            NB_ZP: nz = (i_z == ZW'(Z_TOP)) ? ZW'(Z_TOP - 1) : i_z + ZW'(1);
            default: begin
            end
        endcase
    end

    assign o_idx = IW'(nx) * IW'(YZ) + IW'(ny) * IW'(ZN) + IW'(nz);

endmodule

### design/mdsu_grid.sv
// Voxel storage: the two concentration buffers and the mask, each a synchronous
// memory with registered read, plus the mask clearing sweep after reset.
// Uses mdsu_pkg.
module mdsu_grid import mdsu_pkg::*; #(
    parameter int PLANE_WORDS = 17408,
    parameter int IW          = 15
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_grid_ctl                i_ctl,
    input  logic [IW-1:0]            i_idx,
    input  logic signed [DATA_W-1:0] i_wdata,
    output logic signed [DATA_W-1:0] o_rdata,
    output logic                     o_mask,
    output logic                     o_clr_busy
);

    localparam int CONC_DEPTH = 2 * PLANE_WORDS;
    localparam int CAW        = $clog2(CONC_DEPTH);

    logic [DATA_W-1:0] r_conc_mem [CONC_DEPTH];
    logic              r_mask_mem [PLANE_WORDS];
    logic [DATA_W-1:0] r_rdata;
    logic              r_mask_rd;
    logic              r_clr_busy;
    logic [IW-1:0]     r_clr_addr;

    logic [CAW-1:0]    caddr;
    logic [IW-1:0]     maddr;
    logic              mwe;
    logic              mwd;

    // The second buffer sits directly above the first.
    assign caddr = i_ctl.buf_sel ? CAW'(i_idx) + CAW'(PLANE_WORDS) : CAW'(i_idx);

    assign maddr = r_clr_busy ? r_clr_addr : i_idx;
    assign mwe   = r_clr_busy | i_ctl.wr_mask;
    assign mwd   = r_clr_busy ? 1'b0 : i_ctl.mask_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_conc) begin
            r_conc_mem[caddr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_conc_mem[caddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mwe) begin
            r_mask_mem[maddr] <= mwd;
        end
        if (i_ctl.rd) begin
            r_mask_rd <= r_mask_mem[maddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + IW'(1);
            if (r_clr_addr == IW'(PLANE_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_rdata    = signed'(r_rdata);
    assign o_mask     = r_mask_rd;
    assign o_clr_busy = r_clr_busy;

endmodule

### design/mdsu_alu.sv
// Stencil arithmetic: accumulates the masked neighbour differences and runs the
// Euler step through one shared 32x32 multiplier, one product per cycle. Uses mdsu_pkg.
module mdsu_alu import mdsu_pkg::*; (
    input  logic                     i_clk,
    input  t_alu_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0] i_rdata,
    input  logic                     i_mask,
    input  logic signed [DATA_W-1:0] i_src,
    input  logic signed [DATA_W-1:0] i_stim,
    input  logic [COEF_W-1:0]        i_diff_gain,
    input  logic [COEF_W-1:0]        i_cell_gain,
    input  logic [COEF_W-1:0]        i_decay_rate,
    input  logic [COEF_W-1:0]        i_time_step,
    output logic signed [DATA_W-1:0] o_new
);

    logic signed [DATA_W-1:0] r_c;
    logic signed [35:0]       r_acc;
    logic signed [63:0]       r_prod;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;
    logic signed [DATA_W-1:0] r_r;

    logic signed [DATA_W-1:0] mul_a;
    logic [COEF_W-1:0]        mul_b_u;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [63:0]       n_prod;
    logic signed [39:0]       prod_q;
    logic signed [DATA_W-1:0] prod_sat;
    logic signed [35:0]       diff;

    always_comb begin
        case (i_ctl.mul_sel)
            MUL_DIFF: begin
                mul_a   = sat32(64'(r_acc));
                mul_b_u = i_diff_gain;
            end
            MUL_SRC: begin
                mul_a   = i_src;
                mul_b_u = i_cell_gain;
            end
            MUL_DECAY: begin
                mul_a   = r_c;
                mul_b_u = i_decay_rate;
            end
            MUL_STEP: begin
                mul_a   = r_r;
                mul_b_u = i_time_step;
            end
            default: begin
                mul_a   = r_r;
                mul_b_u = i_time_step;
            end
        endcase
    end

    assign mul_b  = signed'({1'b0, mul_b_u});
    assign n_prod = 64'(mul_a) * 64'(mul_b);

    // Dropping the fraction bits of a two's complement product rounds towards minus infinity.
    assign prod_q   = r_prod[63:FRAC_W];
    assign prod_sat = sat32(64'(prod_q));
    assign diff     = 36'(i_rdata) - 36'(r_c);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_ctl.cap_c) begin
            r_c   <= i_rdata;
            r_acc <= '0;
        end else if (i_ctl.acc_en && i_mask) begin
            r_acc <= r_acc + diff;
        end
        if (i_ctl.cap_a) begin
            r_a <= prod_sat;
        end
        if (i_ctl.cap_b) begin
            r_b <= prod_sat;
        end
        if (i_ctl.cap_r) begin
            r_r <= sat32(64'(r_a) + 64'(r_b) - 64'(prod_sat) + 64'(i_stim));
        end
    end

    assign o_new = sat32(64'(r_c) + 64'(prod_sat));

endmodule

### design/masked_diffusion_stencil_update_core.sv
// Top level of the masked diffusion stencil update core: stream ports, register
// port, operation sequencer and result register. Uses mdsu_pkg, mdsu_addr,
// mdsu_grid and mdsu_alu.
//
//   channel   direction  signals                          beat
//   s_axis    in         tvalid tready tdata[111:0] tuser  one operation
//   m_axis    out        tvalid tready tdata[31:0]         one result word
//   apb       in/out     psel penable pwrite paddr pwdata  one register access
//
// After reset the X_SIZE*Y_SIZE*(Z_TOP+1) mask words (17408 by default) are swept
// clear, and no beat is taken until the sweep finishes; register writes work.
// Each operation runs alone. An update is paced by the single read port, which
// fetches the seven stencil words one per cycle, and by the shared multiplier,
// which forms four products in turn.
// A new beat is taken once the previous result sits in the output register,
// so a stalled m_axis holds back at most one further operation.
module masked_diffusion_stencil_update_core import mdsu_pkg::*; #(
    parameter int X_SIZE = 32,
    parameter int Y_SIZE = 32,
    parameter int Z_TOP  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x[4:0], pos_y[9:5], pos_z[14:10], load_value[46:15], mask_bit[47],
    // cell_source[79:48], stimulus[111:80]
    input  logic [111:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value[31:0]
    output logic [31:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int ZN          = Z_TOP + 1;
    localparam int PLANE_WORDS = X_SIZE * Y_SIZE * ZN;
    localparam int IW          = $clog2(PLANE_WORDS);
    localparam int XW          = $clog2(X_SIZE);
    localparam int YW          = $clog2(Y_SIZE);
    localparam int ZW          = $clog2(ZN);

    t_state                   r_state;
    t_state                   n_state;
    logic [2:0]               r_cnt;
    logic                     r_ret_vld;
    t_nb                      r_ret_nb;
    logic                     r_buf;
    t_op                      r_op;
    logic [XW-1:0]            r_x;
    logic [YW-1:0]            r_y;
    logic [ZW-1:0]            r_z;
    logic signed [DATA_W-1:0] r_load;
    logic                     r_mask;
    logic signed [DATA_W-1:0] r_src;
    logic signed [DATA_W-1:0] r_stim;
    logic signed [DATA_W-1:0] r_res;
    logic                     r_out_vld;
    logic [DATA_W-1:0]        r_out_data;
    logic [COEF_W-1:0]        r_time_step;
    logic [COEF_W-1:0]        r_diff_gain;
    logic [COEF_W-1:0]        r_cell_gain;
    logic [COEF_W-1:0]        r_decay_rate;

    t_op                      in_op;
    logic                     s_acc;
    logic                     out_load;
    logic                     cfg_wr;
    t_reg                     cfg_reg;
    t_nb                      nb_sel;
    t_grid_ctl                grid_ctl;
    t_alu_ctl                 alu_ctl;
    logic [IW-1:0]            idx;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] rdata;
    logic                     mask_rd;
    logic                     clr_busy;
    logic signed [DATA_W-1:0] new_val;

    assign in_op = t_op'(s_axis_tuser);
    assign s_acc = s_axis_tvalid & s_axis_tready;

    // Register port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_reg = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step  <= '0;
            r_diff_gain  <= '0;
            r_cell_gain  <= '0;
            r_decay_rate <= '0;
        end else if (cfg_wr) begin
            case (cfg_reg)
                REG_TIME_STEP:  r_time_step  <= pwdata[COEF_W-1:0];
                REG_DIFF_GAIN:  r_diff_gain  <= pwdata[COEF_W-1:0];
                REG_CELL_GAIN:  r_cell_gain  <= pwdata[COEF_W-1:0];
                REG_DECAY_RATE: r_decay_rate <= pwdata[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_reg)
            REG_TIME_STEP:  prdata = {1'b0, r_time_step};
            REG_DIFF_GAIN:  prdata = {1'b0, r_diff_gain};
            REG_CELL_GAIN:  prdata = {1'b0, r_cell_gain};
            REG_DECAY_RATE: prdata = {1'b0, r_decay_rate};
            default:        prdata = '0;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (!clr_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    case (in_op)
                        OP_LOAD:   n_state = S_LOAD;
                        OP_UPDATE: n_state = S_READ;
                        OP_SWAP:   n_state = S_DONE;
                        OP_READ:   n_state = S_READ;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: n_state = S_DONE;
            S_READ: begin
                if (r_op == OP_READ || r_cnt == 3'(NB_ZP)) begin
                    n_state = S_RD_LAST;
                end
            end
            S_RD_LAST: n_state = (r_op == OP_READ) ? S_DONE : S_MUL_A;
            S_MUL_A:   n_state = S_MUL_B;
            S_MUL_B:   n_state = S_MUL_C;
            S_MUL_C:   n_state = S_SUM;
            S_SUM:     n_state = S_MUL_R;
            S_MUL_R:   n_state = S_WRITE;
            S_WRITE:   n_state = S_DONE;
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready    = 1'b0;
        out_load         = 1'b0;
        nb_sel           = NB_C;
        grid_ctl         = '0;
        grid_ctl.buf_sel = r_buf;
        grid_ctl.mask_val = r_mask;
        alu_ctl          = '0;
        alu_ctl.mul_sel  = MUL_DIFF;
        wdata            = r_load;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_LOAD: begin
                grid_ctl.wr_conc = 1'b1;
                grid_ctl.wr_mask = 1'b1;
            end
            S_READ: begin
                nb_sel      = t_nb'(r_cnt);
                grid_ctl.rd = 1'b1;
            end
            S_MUL_A: alu_ctl.mul_sel = MUL_DIFF;
            S_MUL_B: begin
                alu_ctl.mul_sel = MUL_SRC;
                alu_ctl.cap_a   = 1'b1;
            end
            S_MUL_C: begin
                alu_ctl.mul_sel = MUL_DECAY;
                alu_ctl.cap_b   = 1'b1;
            end
            S_SUM: alu_ctl.cap_r = 1'b1;
            S_MUL_R: alu_ctl.mul_sel = MUL_STEP;
            S_WRITE: begin
                // The new value goes to the buffer that is not being read.
                grid_ctl.wr_conc = 1'b1;
                grid_ctl.buf_sel = ~r_buf;
                wdata            = new_val;
            end
            S_DONE: out_load = !r_out_vld || m_axis_tready;
            default: begin
            end
        endcase
        alu_ctl.cap_c  = r_ret_vld && (r_ret_nb == NB_C);
        alu_ctl.acc_en = r_ret_vld && (r_ret_nb != NB_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_ret_vld <= 1'b0;
            r_ret_nb  <= NB_C;
            r_buf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret_vld <= (r_state == S_READ);
            r_ret_nb  <= t_nb'(r_cnt);
            if (r_state == S_READ) begin
                r_cnt <= r_cnt + 3'd1;
            end else begin
                r_cnt <= '0;
            end
            if (s_acc && in_op == OP_SWAP) begin
                r_buf <= ~r_buf;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op   <= in_op;
            r_x    <= XW'(wrap_coord(s_axis_tdata[4:0], X_SIZE));
            r_y    <= YW'(wrap_coord(s_axis_tdata[9:5], Y_SIZE));
            r_z    <= ({3'b000, s_axis_tdata[14:10]} > 8'(Z_TOP)) ? ZW'(Z_TOP)
                                                                 : ZW'(s_axis_tdata[14:10]);
            r_load <= signed'(s_axis_tdata[46:15]);
            r_mask <= s_axis_tdata[47];
            r_src  <= signed'(s_axis_tdata[79:48]);
            r_stim <= signed'(s_axis_tdata[111:80]);
            r_res  <= '0;
        end else if (r_state == S_RD_LAST && r_op == OP_READ) begin
            r_res <= rdata;
        end else if (r_state == S_WRITE) begin
            r_res <= new_val;
        end
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    mdsu_addr #(
        .X_SIZE (X_SIZE),
        .Y_SIZE (Y_SIZE),
        .Z_TOP  (Z_TOP),
        .XW     (XW),
        .YW     (YW),
        .ZW     (ZW),
        .IW     (IW)
    ) u_addr (
        .i_x   (r_x),
        .i_y   (r_y),
        .i_z   (r_z),
        .i_nb  (nb_sel),
        .o_idx (idx)
    );

    mdsu_grid #(
        .PLANE_WORDS (PLANE_WORDS),
        .IW          (IW)
    ) u_grid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (grid_ctl),
        .i_idx      (idx),
        .i_wdata    (wdata),
        .o_rdata    (rdata),
        .o_mask     (mask_rd),
        .o_clr_busy (clr_busy)
    );

    mdsu_alu u_alu (
        .i_clk        (i_clk),
        .i_ctl        (alu_ctl),
        .i_rdata      (rdata),
        .i_mask       (mask_rd),
        .i_src        (r_src),
        .i_stim       (r_stim),
        .i_diff_gain  (r_diff_gain),
        .i_cell_gain  (r_cell_gain),
        .i_decay_rate (r_decay_rate),
        .i_time_step  (r_time_step),
        .o_new        (new_val)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("beat taken while an operation was still in progress");

    a_quiet_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !(grid_ctl.rd || grid_ctl.wr_conc || grid_ctl.wr_mask))
        else $error("grid accessed during the mask clearing sweep");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside the completion step");

    a_buf_only_on_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_buf != $past(r_buf)) |-> $past(s_acc && in_op == OP_SWAP))
        else $error("buffer select changed without a swap");
`endif

endmodule
